// ----- hdl/dma_page_packet_deframer_macros.svh -----
// Assertion macros for the DMA page packet deframer checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef DMA_PAGE_PACKET_DEFRAMER_MACROS_SVH
`define DMA_PAGE_PACKET_DEFRAMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DPPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/dppd_pkg.sv -----
// Shared types and constants for the DMA page packet deframer.
// No dependencies.
package dppd_pkg;

  // Word index width; indexes wrap at this size.
  localparam int IDX_W = 20;

  // Phase codes of the page walker.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_TSTAMP  = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_PAD     = 3'd5;

  // Decoded packet length word.
  typedef struct packed {
    logic        short_pkt;  // length not above strip count
    logic        oversize;   // delivered length does not fit 16 bits
    logic [15:0] delivered;  // length less strip
    logic [13:0] skip;       // trailer and pad words after the payload
  } len_info_t;

endpackage

// ----- hdl/dma_page_packet_deframer.sv -----
// Top level of the DMA page packet deframer: page walker and result register.
// Depends on dppd_pkg and dppd_len_decode.
//
// Usage:
//   in_*  channel carries the words of a receive DMA page in address order,
//         one beat per word; in_tuser marks word 0 (the qword count).
//   out_* channel carries the payload words of each packet; out_tuser marks
//         the first word, out_tlast the last, and out_tdata also holds the
//         valid byte count and the delivered packet length.
//   cfg_* writes the number of trailer bytes stripped per packet (0..4).
// A payload word is registered and appears on the output in the cycle after
// its input beat is accepted. Header, timestamp, length, trailer and padding
// words produce no output beat.
// Throughput is one beat per cycle: a new word is taken whenever the output
// register is empty or is being drained in the same cycle.
// When the receiver stalls, the output register holds its beat and in_tready
// drops until it is taken.
// Reset clears the walker to idle (awaiting a page start), empties the
// output register and sets the strip count to four.
module dma_page_packet_deframer
  import dppd_pkg::*;
#(
  parameter int PAGE_WORDS   = 524288,
  parameter int HEADER_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,   // strip_trailer_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] page_word
  input  logic        in_tuser,      // [0] page_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,     // [31:0] payload_word, [34:32] valid_bytes,
                                     // [50:35] packet_bytes, [55:51] zero
  output logic        out_tlast,     // last_of_packet
  output logic        out_tuser      // [0] first_of_packet
);

  localparam logic [IDX_W-1:0] HDR_IDX  = IDX_W'(HEADER_WORDS);
  localparam logic [33:0]      PAGE_END = 34'(PAGE_WORDS);
  localparam logic [33:0]      HDR_ADD  = 34'(HEADER_WORDS);

  // Walker state.
  logic [2:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] word_index_r, word_index_nxt;
  logic [IDX_W-1:0] end_index_r, end_index_nxt;
  logic [15:0]      payload_left_r, payload_left_nxt;
  logic [13:0]      skip_left_r, skip_left_nxt;
  logic [15:0]      delivered_r, delivered_nxt;
  logic             first_pending_r, first_pending_nxt;
  logic [2:0]       strip_r;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_word_r, out_word_nxt;
  logic [2:0]       out_vb_r, out_vb_nxt;
  logic [15:0]      out_len_r, out_len_nxt;
  logic             out_first_r, out_first_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_beat;
  logic             emit;
  logic [IDX_W-1:0] idx_adv;
  logic             at_end;
  logic [33:0]      page_end;
  logic             page_bad;
  logic [2:0]       vb;
  logic [15:0]      left_after;
  len_info_t        len_info;

  dppd_len_decode u_len (
    .len   (in_tdata),
    .strip (strip_r),
    .info  (len_info)
  );

  // Take a new word whenever the result register is free or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    idx_adv    = word_index_r + IDX_W'(1);
    at_end     = (idx_adv >= end_index_r);
    page_end   = {1'b0, in_tdata, 1'b0} + HDR_ADD;
    page_bad   = (in_tdata == 32'd0) || (page_end > PAGE_END);
    vb         = (payload_left_r >= 16'd4) ? 3'd4 : payload_left_r[2:0];
    left_after = payload_left_r - {13'd0, vb};

    phase_nxt         = phase_r;
    word_index_nxt    = word_index_r;
    end_index_nxt     = end_index_r;
    payload_left_nxt  = payload_left_r;
    skip_left_nxt     = skip_left_r;
    delivered_nxt     = delivered_r;
    first_pending_nxt = first_pending_r;
    emit              = 1'b0;

    if (in_tuser) begin
      // Page start restarts the walker in any phase.
      payload_left_nxt  = '0;
      skip_left_nxt     = '0;
      first_pending_nxt = 1'b0;
      word_index_nxt    = IDX_W'(1);
      if (page_bad) begin
        phase_nxt     = PH_IDLE;
        end_index_nxt = '0;
      end else begin
        end_index_nxt = page_end[IDX_W-1:0];
        if (IDX_W'(1) >= HDR_IDX) begin
          phase_nxt = (IDX_W'(1) >= page_end[IDX_W-1:0]) ? PH_IDLE : PH_TSTAMP;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          word_index_nxt = idx_adv;
          if (idx_adv >= HDR_IDX) begin
            phase_nxt = at_end ? PH_IDLE : PH_TSTAMP;
          end
        end
        PH_TSTAMP: begin
          word_index_nxt = idx_adv;
          phase_nxt      = PH_LENGTH;
        end
        PH_LENGTH: begin
          word_index_nxt = idx_adv;
          if (len_info.short_pkt) begin
            // Drop the whole padded payload of a short packet.
            skip_left_nxt    = len_info.skip;
            payload_left_nxt = '0;
            if (len_info.skip != 14'd0) begin
              phase_nxt = PH_PAD;
            end else begin
              phase_nxt = at_end ? PH_IDLE : PH_TSTAMP;
            end
          end else if (len_info.oversize) begin
            // Corrupt page: drop the rest.
            phase_nxt = PH_IDLE;
          end else begin
            delivered_nxt     = len_info.delivered;
            payload_left_nxt  = len_info.delivered;
            first_pending_nxt = 1'b1;
            skip_left_nxt     = len_info.skip;
            phase_nxt         = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          word_index_nxt    = idx_adv;
          emit              = 1'b1;
          first_pending_nxt = 1'b0;
          payload_left_nxt  = left_after;
          if (left_after == 16'd0) begin
            if (skip_left_r != 14'd0) begin
              phase_nxt = PH_PAD;
            end else begin
              phase_nxt = at_end ? PH_IDLE : PH_TSTAMP;
            end
          end
        end
        PH_PAD: begin
          word_index_nxt = idx_adv;
          if (skip_left_r > 14'd1) begin
            skip_left_nxt = skip_left_r - 14'd1;
          end else begin
            skip_left_nxt = '0;
            phase_nxt     = at_end ? PH_IDLE : PH_TSTAMP;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result register: drain on a taken beat, load on an emitting input beat.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_vb_nxt    = out_vb_r;
    out_len_nxt   = out_len_r;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    if (in_beat && emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = in_tdata;
      out_vb_nxt    = vb;
      out_len_nxt   = delivered_r;
      out_first_nxt = first_pending_r;
      out_last_nxt  = (payload_left_r <= 16'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      word_index_r    <= '0;
      end_index_r     <= '0;
      payload_left_r  <= '0;
      skip_left_r     <= '0;
      delivered_r     <= '0;
      first_pending_r <= 1'b0;
      strip_r         <= 3'd4;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_beat) begin
        phase_r         <= phase_nxt;
        word_index_r    <= word_index_nxt;
        end_index_r     <= end_index_nxt;
        payload_left_r  <= payload_left_nxt;
        skip_left_r     <= skip_left_nxt;
        delivered_r     <= delivered_nxt;
        first_pending_r <= first_pending_nxt;
      end
      if (cfg_wr_en) begin
        strip_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    out_vb_r    <= out_vb_nxt;
    out_len_r   <= out_len_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_len_r, out_vb_r, out_word_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_first_r;

endmodule

// ----- hdl/dppd_len_decode.sv -----
// Decodes a packet length word into delivered length and words to skip.
// Depends on dppd_pkg.
module dppd_len_decode
  import dppd_pkg::*;
(
  input  logic [31:0] len,
  input  logic [2:0]  strip,
  output len_info_t   info
);

  logic [2:0]  strip_eff;
  logic [31:0] delivered_full;
  logic [17:0] pad_sum;
  logic [15:0] padded;
  logic [16:0] dw_sum;
  logic [15:0] skip_full;

  always_comb begin
    // Strip codes above four act as four.
    strip_eff      = (strip > 3'd4) ? 3'd4 : strip;
    delivered_full = len - {29'd0, strip_eff};
    // Payload is padded to whole qwords: two words per eight bytes.
    pad_sum        = {1'b0, len[16:0]} + 18'd7;
    padded         = {pad_sum[17:3], 1'b0};
    dw_sum         = {1'b0, delivered_full[15:0]} + 17'd3;
    skip_full      = padded - {1'b0, dw_sum[16:2]};

    info.short_pkt = (len <= {29'd0, strip_eff});
    info.oversize  = |delivered_full[31:16];
    info.delivered = delivered_full[15:0];
    info.skip      = info.short_pkt ? padded[13:0] : skip_full[13:0];
  end

endmodule

// ----- hdl/dppd_checker.sv -----
// Port-level checker for the DMA page packet deframer, bound to the top level.
// Depends on dma_page_packet_deframer_macros.svh.
`include "dma_page_packet_deframer_macros.svh"

module dppd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  logic [2:0]  vb;
  logic [15:0] pkt_len;

  assign vb      = out_tdata[34:32];
  assign pkt_len = out_tdata[50:35];

  // Hold a stalled beat.
  `DPPD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output beat changed")

  // Empty the output right after reset.
  `DPPD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  // Fill every word but the last of a packet.
  `DPPD_ASSERT(a_full_words, out_tvalid && !out_tlast |-> vb == 3'd4, "non-last word not full")

  // A one-word packet carries exactly its length.
  `DPPD_ASSERT(a_single_word, out_tvalid && out_tuser && out_tlast |-> pkt_len == 16'(vb), "one-word length")

  // Keep the byte count in range.
  `DPPD_ASSERT(a_vb_range, out_tvalid |-> (vb == 3'd1 || vb == 3'd2 || vb == 3'd3 || vb == 3'd4), "valid byte count out of range")

endmodule

bind dma_page_packet_deframer dppd_checker u_dppd_checker (.*);
